>>> rtl/mct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse code translator package
// Shared types, the code table and the table lookup functions.
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int CodeCount = 41;
    localparam logic [2:0] MaxSymbols = 3'd6;

    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharDash  = 8'h2D;
    localparam logic [7:0] CharSpace = 8'h20;

    typedef enum logic [0:0] {
        MCT_IDLE,
        MCT_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic any_result;
        logic last_beat;
    } status_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] len;
        logic [5:0] bits;
    } enc_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] char_val;
    } dec_t;

    localparam logic [7:0] CODE_CHAR [CodeCount] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
        8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
        8'h2E, 8'h2C, 8'h3A, 8'h3F, 8'h27,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
    };

    localparam logic [2:0] CODE_LEN [CodeCount] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    // Bit i is set when symbol i of the code is a dash.
    localparam logic [5:0] CODE_BITS [CodeCount] = '{
        6'b000010, 6'b000001, 6'b000101, 6'b000001, 6'b000000,
        6'b000100, 6'b000011, 6'b000000, 6'b000000, 6'b001110,
        6'b000101, 6'b000010, 6'b000011, 6'b000001, 6'b000111,
        6'b000110, 6'b001011, 6'b000010, 6'b000000, 6'b000001,
        6'b000100, 6'b001000, 6'b000110, 6'b001001, 6'b001101,
        6'b000011,
        6'b101010, 6'b110011, 6'b000111, 6'b001100, 6'b011110,
        6'b011111, 6'b011110, 6'b011100, 6'b011000, 6'b010000,
        6'b000000, 6'b000001, 6'b000011, 6'b000111, 6'b001111
    };

    function automatic enc_t enc_lookup(logic [7:0] c);
        enc_t res;
        res = '0;
        for (int k = 0; k < CodeCount; k++) begin
            if (!res.hit && CODE_CHAR[k] == c) begin
                res.hit  = 1'b1;
                res.len  = CODE_LEN[k];
                res.bits = CODE_BITS[k];
            end
        end
        return res;
    endfunction

    function automatic dec_t dec_lookup(logic [2:0] len, logic [5:0] bits);
        dec_t res;
        res = '0;
        for (int k = 0; k < CodeCount; k++) begin
            if (!res.hit && CODE_LEN[k] == len && CODE_BITS[k] == bits) begin
                res.hit      = 1'b1;
                res.char_val = CODE_CHAR[k];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/mct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse code translator controller
// Accepts one byte, then hands out its result beats one by one.
// ----------------------------------------------------------------------------
module mct_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire mct_pkg::status_t status,
    output mct_pkg::cmd_t         cmd
);

    mct_pkg::state_t state_reg;
    mct_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mct_pkg::MCT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            mct_pkg::MCT_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && status.any_result) begin
                    state_next = mct_pkg::MCT_EMIT;
                end
            end
            mct_pkg::MCT_EMIT: begin
                m_valid     = 1'b1;
                cmd.advance = m_ready;
                if (m_ready && status.last_beat) begin
                    state_next = mct_pkg::MCT_IDLE;
                end
            end
            default: begin
                state_next = mct_pkg::MCT_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/mct_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse code translator datapath
// Phrase and symbol group state, table lookups and the result beat buffer.
// ----------------------------------------------------------------------------
module mct_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [7:0]    s_char_in,
    input  wire logic          s_phrase_end,
    output logic [7:0]         m_char_out,
    output logic               m_last_of_run,
    input  wire mct_pkg::cmd_t cmd,
    output mct_pkg::status_t   status
);

    logic       decode_mode_reg, decode_mode_next;
    logic       phrase_start_reg, phrase_start_next;
    logic [5:0] sym_bits_reg, sym_bits_next;
    logic [2:0] sym_count_reg, sym_count_next;
    logic       sym_invalid_reg, sym_invalid_next;

    logic       emit_dec_reg, emit_dec_next;
    logic [7:0] emit_char_reg, emit_char_next;
    logic [5:0] emit_bits_reg, emit_bits_next;
    logic [2:0] emit_len_reg, emit_len_next;
    logic [2:0] emit_total_reg, emit_total_next;
    logic [2:0] idx_reg, idx_next;

    logic          eff_dec;
    logic          flush;
    logic [5:0]    bits_b, bits_u;
    logic [2:0]    cnt_b, cnt_u;
    logic          inv_b, inv_u;
    logic [5:0]    bits_shift;
    mct_pkg::enc_t enc;
    mct_pkg::dec_t dec;

    always_comb begin
        eff_dec = phrase_start_reg ? (s_char_in == mct_pkg::CharDot ||
                                      s_char_in == mct_pkg::CharDash)
                                   : decode_mode_reg;
        flush   = (s_char_in == mct_pkg::CharSpace) || s_phrase_end;

        bits_b = phrase_start_reg ? 6'd0 : sym_bits_reg;
        cnt_b  = phrase_start_reg ? 3'd0 : sym_count_reg;
        inv_b  = phrase_start_reg ? 1'b0 : sym_invalid_reg;

        bits_u = bits_b;
        cnt_u  = cnt_b;
        inv_u  = inv_b;
        if (s_char_in != mct_pkg::CharSpace) begin
            if (cnt_b >= mct_pkg::MaxSymbols) begin
                inv_u = 1'b1;
            end else begin
                if (s_char_in == mct_pkg::CharDash) begin
                    bits_u = bits_b | (6'd1 << cnt_b);
                end else if (s_char_in != mct_pkg::CharDot) begin
                    inv_u = 1'b1;
                end
                cnt_u = cnt_b + 3'd1;
            end
        end

        enc = mct_pkg::enc_lookup(s_char_in);
        dec = mct_pkg::dec_lookup(cnt_u, bits_u);

        emit_dec_next  = eff_dec;
        emit_char_next = dec.char_val;
        emit_bits_next = enc.bits;
        emit_len_next  = enc.len;
        if (eff_dec) begin
            emit_total_next = (flush && !inv_u && dec.hit) ? 3'd1 : 3'd0;
        end else begin
            emit_total_next = enc.hit ? enc.len + 3'd1 : 3'd0;
        end

        decode_mode_next  = eff_dec;
        phrase_start_next = s_phrase_end;
        if (eff_dec && !flush) begin
            sym_bits_next    = bits_u;
            sym_count_next   = cnt_u;
            sym_invalid_next = inv_u;
        end else if (eff_dec || phrase_start_reg) begin
            sym_bits_next    = 6'd0;
            sym_count_next   = 3'd0;
            sym_invalid_next = 1'b0;
        end else begin
            sym_bits_next    = sym_bits_reg;
            sym_count_next   = sym_count_reg;
            sym_invalid_next = sym_invalid_reg;
        end

        idx_next = cmd.load ? 3'd0 : idx_reg + 3'd1;

        status.any_result = (emit_total_next != 3'd0);
        status.last_beat  = (idx_reg == emit_total_reg - 3'd1);

        bits_shift    = emit_bits_reg >> idx_reg;
        m_last_of_run = status.last_beat;
        if (emit_dec_reg) begin
            m_char_out = emit_char_reg;
        end else if (idx_reg < emit_len_reg) begin
            m_char_out = bits_shift[0] ? mct_pkg::CharDash : mct_pkg::CharDot;
        end else begin
            m_char_out = mct_pkg::CharSpace;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_mode_reg  <= 1'b0;
            phrase_start_reg <= 1'b1;
            sym_bits_reg     <= 6'd0;
            sym_count_reg    <= 3'd0;
            sym_invalid_reg  <= 1'b0;
            idx_reg          <= 3'd0;
        end else begin
            if (cmd.load) begin
                decode_mode_reg  <= decode_mode_next;
                phrase_start_reg <= phrase_start_next;
                sym_bits_reg     <= sym_bits_next;
                sym_count_reg    <= sym_count_next;
                sym_invalid_reg  <= sym_invalid_next;
            end
            if (cmd.load || cmd.advance) begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            emit_dec_reg   <= emit_dec_next;
            emit_char_reg  <= emit_char_next;
            emit_bits_reg  <= emit_bits_next;
            emit_len_reg   <= emit_len_next;
            emit_total_reg <= emit_total_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/morse_code_translator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse code translator core
// Encodes text bytes to dots and dashes, or decodes symbol groups to text.
//
// Channel  Ports                               Beat
// input    s_valid s_ready s_char_in           one phrase byte
//          s_phrase_end
// output   m_valid m_ready m_char_out          one output character
//          m_last_of_run
//
// A byte is taken while idle; its results then leave one per cycle unless
// the output stalls, at most seven for a six-symbol code. The beat counter
// of the result buffer steps through them. Reset brings the block to the
// start of a phrase. A stalled output beat holds the block, and no new byte
// is taken until every result of the current byte has gone.
// ----------------------------------------------------------------------------
module morse_code_translator_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_phrase_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_char_out,
    output logic            m_last_of_run
);

    mct_pkg::cmd_t    cmd;
    mct_pkg::status_t status;

    mct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mct_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_char_in     (s_char_in),
        .s_phrase_end  (s_phrase_end),
        .m_char_out    (m_char_out),
        .m_last_of_run (m_last_of_run),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
`default_nettype wire

>>> rtl/mct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse code translator checker
// Port-level checks on beat ordering and stalled beats, attached to the core by bind.
// ----------------------------------------------------------------------------
module mct_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_char_out,
    input wire logic       m_last_of_run
);

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input ready while a result beat is pending.");

    a_after_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (s_ready || m_valid))
        else $error("Block neither idle nor emitting after a byte.");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_run) |=> (s_ready && !m_valid))
        else $error("Block did not return to idle after the final beat.");

    a_run_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("Run of beats ended without a final beat.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_char_out) && $stable(m_last_of_run)))
        else $error("Stalled output beat changed.");

endmodule

bind morse_code_translator_core mct_checker u_mct_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_char_out    (m_char_out),
    .m_last_of_run (m_last_of_run)
);
`default_nettype wire
